@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL core (whp_core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
        else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEXT(label, clk, rstn, trig, cond, msg)
`endif
`endif

@@ sv/whp_pkg.sv @@
// Package with constants and types of the WAV header parser.
package whp_pkg;

    localparam int POSITION_BITS_DEF = 32;

    localparam logic [31:0] MIN_HEADER_LEN = 32'd44;
    localparam logic [31:0] MAGIC_RIFF     = 32'h4646_4952;
    localparam logic [31:0] MAGIC_WAVE     = 32'h4556_4157;
    localparam logic [31:0] MAGIC_DATA     = 32'h6174_6164;
    localparam logic [31:0] WALK_START     = 32'd12;
    localparam logic [31:0] CHUNK_HDR      = 32'd8;

    // Byte offsets of the fixed header fields (offset of their last byte).
    localparam logic [31:0] OFS_RIFF_END     = 32'd3;
    localparam logic [31:0] OFS_WAVE_END     = 32'd11;
    localparam logic [31:0] OFS_CHANNELS_END = 32'd23;
    localparam logic [31:0] OFS_RATE_END     = 32'd27;
    localparam logic [31:0] OFS_BITS_END     = 32'd35;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } whp_beat_t;

    typedef struct packed {
        logic        header_ok;
        logic        data_chunk_found;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic [31:0] payload_offset;
    } whp_result_t;

endpackage

@@ sv/wav_header_parser.sv @@
// Result: a beat with last_byte passes the input register; once the core takes it, the result register is loaded.
// Throughput: one byte beat per cycle; an input register and a result register
// decouple the channels, so only a last beat waits while a result is not taken.
// Reset: aresetn is synchronous, active low; clears all stream state and both
// valid flags, and restarts the chunk walk at offset 12.
module wav_header_parser
    import whp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_byte_in,
    input  logic               s_last_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_header_ok,
    output logic               m_data_chunk_found,
    output logic signed [31:0] m_sample_rate,
    output logic [15:0]        m_channel_count,
    output logic [15:0]        m_sample_bits,
    output logic [31:0]        m_payload_offset
);

    whp_beat_t   s_beat;
    whp_beat_t   beat;
    logic        beat_valid;
    logic        beat_take;
    whp_result_t result;

    assign s_beat.byte_in   = s_byte_in;
    assign s_beat.last_byte = s_last_byte;

    whp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    whp_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    assign m_header_ok        = result.header_ok;
    assign m_data_chunk_found = result.data_chunk_found;
    assign m_sample_rate      = $signed(result.sample_rate);
    assign m_channel_count    = result.channel_count;
    assign m_sample_bits      = result.sample_bits;
    assign m_payload_offset   = result.payload_offset;

endmodule

@@ sv/whp_in_reg.sv @@
// Input register stage of the WAV header parser.
module whp_in_reg
    import whp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  whp_beat_t s_beat,
    output logic      beat_valid,
    output whp_beat_t beat,
    input  logic      beat_take
);

    logic      valid_reg;
    logic      valid_next;
    whp_beat_t beat_reg;

    assign s_ready    = !valid_reg || beat_take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

@@ sv/whp_core.sv @@
// Header state, chunk walk and result register of the WAV header parser.
`include "assert_macros.svh"
module whp_core
    import whp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        beat_valid,
    input  whp_beat_t   beat,
    output logic        beat_take,
    output logic        m_valid,
    input  logic        m_ready,
    output whp_result_t result
);

    localparam int PW = POSITION_BITS;
    localparam int SW = ((PW > 33) ? PW : 33) + 2;
    localparam logic [PW-1:0] LIMIT = '1;

    logic [PW-1:0] byte_count_reg,  byte_count_next;
    logic [31:0]   recent_reg,      recent_next;
    logic          riff_reg,        riff_next;
    logic          wave_reg,        wave_next;
    logic [15:0]   channels_reg,    channels_next;
    logic [31:0]   rate_reg,        rate_next;
    logic [15:0]   bits_reg,        bits_next;
    logic [PW-1:0] next_pos_reg,    next_pos_next;
    logic          cur_data_reg,    cur_data_next;
    logic          search_done_reg, search_done_next;
    logic          data_found_reg,  data_found_next;
    logic [PW-1:0] found_off_reg,   found_off_next;

    logic        m_valid_reg, m_valid_next;
    whp_result_t result_reg,  result_next;

    assign beat_take = beat_valid && (!beat.last_byte || !m_valid_reg || m_ready);

    always_comb begin
        logic [PW-1:0] idx;
        logic [32:0]   padded;
        logic [SW-1:0] step;
        logic          ok;

        idx              = byte_count_reg;
        padded           = '0;
        step             = '0;
        ok               = 1'b0;
        byte_count_next  = byte_count_reg;
        recent_next      = recent_reg;
        riff_next        = riff_reg;
        wave_next        = wave_reg;
        channels_next    = channels_reg;
        rate_next        = rate_reg;
        bits_next        = bits_reg;
        next_pos_next    = next_pos_reg;
        cur_data_next    = cur_data_reg;
        search_done_next = search_done_reg;
        data_found_next  = data_found_reg;
        found_off_next   = found_off_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        result_next      = result_reg;

        if (beat_take) begin
            // Once the counter saturates, a beat only counts toward the length test.
            if (byte_count_reg != LIMIT) begin
                recent_next     = {beat.byte_in, recent_reg[31:8]};
                byte_count_next = byte_count_reg + PW'(1);
                if (idx == PW'(OFS_RIFF_END))     riff_next     = (recent_next == MAGIC_RIFF);
                if (idx == PW'(OFS_WAVE_END))     wave_next     = (recent_next == MAGIC_WAVE);
                if (idx == PW'(OFS_CHANNELS_END)) channels_next = recent_next[31:16];
                if (idx == PW'(OFS_RATE_END))     rate_next     = recent_next;
                if (idx == PW'(OFS_BITS_END))     bits_next     = recent_next[31:16];

                if (!search_done_reg) begin
                    if (idx == next_pos_reg + PW'(3)) begin
                        cur_data_next = (recent_next == MAGIC_DATA);
                    end else if (idx == next_pos_reg + PW'(7)) begin
                        if (cur_data_reg) begin
                            found_off_next   = next_pos_reg + PW'(CHUNK_HDR);
                            search_done_next = 1'b1;
                            data_found_next  = 1'b1;
                        end else begin
                            // Advance past header and even-padded body.
                            padded        = {1'b0, recent_next} + 33'd1;
                            padded[0]     = 1'b0;
                            step          = SW'(next_pos_reg) + SW'(CHUNK_HDR) + SW'(padded);
                            next_pos_next = step[PW-1:0];
                            cur_data_next = 1'b0;
                            if (step + SW'(CHUNK_HDR) > SW'(LIMIT)) begin
                                search_done_next = 1'b1;
                            end
                        end
                    end
                end
            end

            if (beat.last_byte) begin
                ok           = (byte_count_next >= PW'(MIN_HEADER_LEN)) && riff_next && wave_next;
                m_valid_next = 1'b1;
                result_next  = '0;
                if (ok) begin
                    result_next.header_ok        = 1'b1;
                    result_next.data_chunk_found = data_found_next;
                    result_next.sample_rate      = rate_next;
                    result_next.channel_count    = channels_next;
                    result_next.sample_bits      = bits_next;
                    result_next.payload_offset   = data_found_next ? 32'(found_off_next)
                                                                   : MIN_HEADER_LEN;
                end
                // Drop all stream state for the next file.
                byte_count_next  = '0;
                recent_next      = '0;
                riff_next        = 1'b0;
                wave_next        = 1'b0;
                channels_next    = '0;
                rate_next        = '0;
                bits_next        = '0;
                next_pos_next    = PW'(WALK_START);
                cur_data_next    = 1'b0;
                search_done_next = 1'b0;
                data_found_next  = 1'b0;
                found_off_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            recent_reg      <= '0;
            riff_reg        <= 1'b0;
            wave_reg        <= 1'b0;
            channels_reg    <= '0;
            rate_reg        <= '0;
            bits_reg        <= '0;
            next_pos_reg    <= PW'(WALK_START);
            cur_data_reg    <= 1'b0;
            search_done_reg <= 1'b0;
            data_found_reg  <= 1'b0;
            found_off_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            byte_count_reg  <= byte_count_next;
            recent_reg      <= recent_next;
            riff_reg        <= riff_next;
            wave_reg        <= wave_next;
            channels_reg    <= channels_next;
            rate_reg        <= rate_next;
            bits_reg        <= bits_next;
            next_pos_reg    <= next_pos_next;
            cur_data_reg    <= cur_data_next;
            search_done_reg <= search_done_next;
            data_found_reg  <= data_found_next;
            found_off_reg   <= found_off_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

    `ASSERT_CLK(a_found_ends_search, aclk, aresetn, !data_found_reg || search_done_reg, "data chunk found while search still open")
    `ASSERT_CLK(a_pos_in_range, aclk, aresetn, search_done_reg || (next_pos_reg <= LIMIT - PW'(CHUNK_HDR)), "open chunk position beyond counter range")
    `ASSERT_CLK(a_invalid_zero, aclk, aresetn, !m_valid_reg || result_reg.header_ok || (result_reg == '0), "invalid header with nonzero fields")
    `ASSERT_NEXT(a_last_clears, aclk, aresetn, beat_take && beat.last_byte, byte_count_reg == '0 && m_valid_reg, "last beat did not clear state or raise result")

endmodule

@@ tb/wav_header_parser_checker.sv @@
// Checker for the WAV header parser: predicts each header result and compares it.
`timescale 1ns / 1ps

module wav_header_parser_checker
    import whp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_header_ok,
    input  logic        m_data_chunk_found,
    input  logic [31:0] m_sample_rate,
    input  logic [15:0] m_channel_count,
    input  logic [15:0] m_sample_bits,
    input  logic [31:0] m_payload_offset,
    output int          fail_count,
    output int          pending_count,
    output int          headers_checked,
    output int          headers_valid,
    output int          chunks_found
);

    localparam logic [63:0] POS_LIMIT = (64'd1 << POSITION_BITS) - 64'd1;

    // Running view of the stream being parsed.
    logic [63:0] stream_len;
    logic [31:0] window;
    bit          riff_ok;
    bit          wave_ok;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [63:0] chunk_pos;
    bit          chunk_is_data;
    bit          walk_over;
    logic [63:0] data_ofs;

    whp_result_t expected_headers[$];
    int          mismatches = 0;
    int          checked    = 0;
    int          valid_seen = 0;
    int          found_seen = 0;

    function automatic void clear_stream();
        stream_len    = '0;
        window        = '0;
        riff_ok       = 1'b0;
        wave_ok       = 1'b0;
        chans         = '0;
        rate          = '0;
        bits          = '0;
        chunk_pos     = 64'(WALK_START);
        chunk_is_data = 1'b0;
        walk_over     = 1'b0;
        data_ofs      = '0;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] header %0d %s: got 0x%h, expected 0x%h",
                 $time, checked, field, got, want);
        mismatches++;
    endtask

    task automatic parse_stream_byte(input logic [7:0] b, input logic last);
        logic [63:0] idx;
        logic [63:0] nxt;
        whp_result_t hdr;
        bit          ok;
        bit          found;
        // Bytes past the position limit only count toward the length test.
        if (stream_len < POS_LIMIT) begin
            idx        = stream_len;
            window     = {b, window[31:8]};
            stream_len = idx + 64'd1;
            if (idx == OFS_RIFF_END) riff_ok = (window == MAGIC_RIFF);
            if (idx == OFS_WAVE_END) wave_ok = (window == MAGIC_WAVE);
            if (idx == OFS_CHANNELS_END) chans = window[31:16];
            if (idx == OFS_RATE_END) rate = window;
            if (idx == OFS_BITS_END) bits = window[31:16];
            if (!walk_over) begin
                if (idx == chunk_pos + 64'd3) begin
                    chunk_is_data = (window == MAGIC_DATA);
                end else if (idx == chunk_pos + 64'd7) begin
                    if (chunk_is_data) begin
                        data_ofs  = chunk_pos + 64'(CHUNK_HDR);
                        walk_over = 1'b1;
                    end else begin
                        // Skip the chunk body, padded up to an even length.
                        nxt = chunk_pos + 64'(CHUNK_HDR)
                            + ((64'(window) + 64'd1) & ~64'd1);
                        chunk_pos     = nxt;
                        chunk_is_data = 1'b0;
                        if (nxt + 64'(CHUNK_HDR) > POS_LIMIT) walk_over = 1'b1;
                    end
                end
            end
        end
        if (last) begin
            ok    = (stream_len >= 64'(MIN_HEADER_LEN)) && riff_ok && wave_ok;
            found = walk_over && (data_ofs != 64'd0);
            hdr   = '0;
            if (ok) begin
                hdr.header_ok        = 1'b1;
                hdr.data_chunk_found = found;
                hdr.sample_rate      = rate;
                hdr.channel_count    = chans;
                hdr.sample_bits      = bits;
                hdr.payload_offset   = found ? data_ofs[31:0] : MIN_HEADER_LEN;
            end
            expected_headers.push_back(hdr);
            clear_stream();
        end
    endtask

    task automatic compare_header();
        whp_result_t want;
        if (expected_headers.size() == 0) begin
            flag_mismatch("result with no stream closed", 32'd0, 32'd0);
            return;
        end
        want = expected_headers.pop_front();
        checked++;
        if (want.header_ok) valid_seen++;
        if (want.data_chunk_found) found_seen++;
        if (m_header_ok !== want.header_ok)
            flag_mismatch("header_ok", 32'(m_header_ok), 32'(want.header_ok));
        if (m_data_chunk_found !== want.data_chunk_found)
            flag_mismatch("data_chunk_found", 32'(m_data_chunk_found),
                          32'(want.data_chunk_found));
        if (m_sample_rate !== want.sample_rate)
            flag_mismatch("sample_rate", m_sample_rate, want.sample_rate);
        if (m_channel_count !== want.channel_count)
            flag_mismatch("channel_count", 32'(m_channel_count), 32'(want.channel_count));
        if (m_sample_bits !== want.sample_bits)
            flag_mismatch("sample_bits", 32'(m_sample_bits), 32'(want.sample_bits));
        if (m_payload_offset !== want.payload_offset)
            flag_mismatch("payload_offset", m_payload_offset, want.payload_offset);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_stream();
            expected_headers.delete();
        end else begin
            if (m_valid && m_ready) compare_header();
            if (s_valid && s_ready) parse_stream_byte(s_byte_in, s_last_byte);
        end
        fail_count      <= mismatches;
        pending_count   <= expected_headers.size();
        headers_checked <= checked;
        headers_valid   <= valid_seen;
        chunks_found    <= found_seen;
    end

endmodule

@@ tb/wav_header_parser_tb.sv @@
// Testbench top for the WAV header parser: clock, reset, byte streams and verdict.
`timescale 1ns / 1ps

module wav_header_parser_tb;
    import whp_pkg::*;

    localparam int          RESET_CYCLES   = 11;
    localparam int          ITEM_TARGET    = 1650;
    localparam int          MIN_STREAMS    = 24;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [31:0] FMT_TAG        = 32'h2074_6d66; // "fmt " in file order

    typedef enum int {
        STREAM_WELL,
        STREAM_NO_DATA,
        STREAM_CUT_HEADER,
        STREAM_BAD_MAGIC,
        STREAM_SHORT,
        STREAM_HUGE_CHUNK,
        STREAM_NOISE,
        STREAM_DATA_FIRST,
        STREAM_KINDS
    } stream_kind_t;

    logic               aclk;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [7:0]         s_byte_in   = 8'd0;
    logic               s_last_byte = 1'b0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic               m_header_ok;
    logic               m_data_chunk_found;
    logic signed [31:0] m_sample_rate;
    logic [15:0]        m_channel_count;
    logic [15:0]        m_sample_bits;
    logic [31:0]        m_payload_offset;

    int fail_count;
    int pending_count;
    int headers_checked;
    int headers_valid;
    int chunks_found;

    int         s_idle_pct   = 28;
    int         m_idle_pct   = 51;
    bit         hold_request = 1'b0;
    int         bytes_sent   = 0;
    logic [7:0] stream_bytes[$];

    wav_header_parser i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_byte_in          (s_byte_in),
        .s_last_byte        (s_last_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_header_ok        (m_header_ok),
        .m_data_chunk_found (m_data_chunk_found),
        .m_sample_rate      (m_sample_rate),
        .m_channel_count    (m_channel_count),
        .m_sample_bits      (m_sample_bits),
        .m_payload_offset   (m_payload_offset)
    );

    wav_header_parser_checker i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_byte_in          (s_byte_in),
        .s_last_byte        (s_last_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_header_ok        (m_header_ok),
        .m_data_chunk_found (m_data_chunk_found),
        .m_sample_rate      (m_sample_rate),
        .m_channel_count    (m_channel_count),
        .m_sample_bits      (m_sample_bits),
        .m_payload_offset   (m_payload_offset),
        .fail_count         (fail_count),
        .pending_count      (pending_count),
        .headers_checked    (headers_checked),
        .headers_valid      (headers_valid),
        .chunks_found       (chunks_found)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) stream_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void push_random(input int n);
        for (int i = 0; i < n; i++) stream_bytes.push_back(8'($urandom));
    endfunction

    function automatic void build_stream(input stream_kind_t kind, input bit tight);
        int          fmt_size;
        int          extras;
        int          cut_len;
        int          pick;
        logic [31:0] csize;
        stream_bytes.delete();
        if (kind == STREAM_NOISE) begin
            push_random($urandom_range(64, 1));
            return;
        end
        push_word(MAGIC_RIFF);
        push_word($urandom);
        push_word(MAGIC_WAVE);
        if (kind == STREAM_DATA_FIRST) begin
            // Data chunk right at the start of the walk; fixed fields land in its body.
            push_word(MAGIC_DATA);
            push_word($urandom);
            push_random($urandom_range(40, 20));
            return;
        end
        if (tight) fmt_size = 16;
        else if (kind == STREAM_CUT_HEADER) fmt_size = $urandom_range(40, 16);
        else fmt_size = $urandom_range(1) ? 16 : $urandom_range(31, 14);
        push_word(FMT_TAG);
        push_word(fmt_size);
        push_random(fmt_size + fmt_size % 2);
        extras = tight ? 0 : $urandom_range(1);
        repeat (extras) begin
            csize = $urandom_range(9);
            push_word($urandom);
            push_word(csize);
            push_random(csize + csize % 2);
        end
        if (kind == STREAM_HUGE_CHUNK) begin
            // Size so large that the walk runs out of position range.
            push_word($urandom);
            push_word($urandom_range(32'hFFFF_FFFF, 32'hFFFF_FFE0));
            push_random($urandom_range(4));
        end
        case (kind)
            STREAM_NO_DATA: begin
                if ($urandom_range(1)) begin
                    push_word($urandom);
                    push_word($urandom_range(4000, 64));
                end
                push_random($urandom_range(12));
            end
            STREAM_CUT_HEADER: begin
                push_word(MAGIC_DATA);
                push_random($urandom_range(3));
            end
            default: begin
                push_word(MAGIC_DATA);
                push_word($urandom);
                if (!tight) push_random($urandom_range(8));
            end
        endcase
        if (kind == STREAM_BAD_MAGIC) begin
            pick = $urandom_range(7);
            if (pick >= 4) pick += 4;
            stream_bytes[pick] ^= 8'(1 << $urandom_range(7));
        end
        if (kind == STREAM_SHORT) begin
            cut_len = $urandom_range(43, 1);
            while (stream_bytes.size() > cut_len) void'(stream_bytes.pop_back());
        end
    endfunction

    // Offer one beat, idling first at the current rate; return once it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_byte_in   <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_stream();
        foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    endtask

    initial begin : receiver
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                // Hold off long enough for the parser to back up into its input.
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= m_idle_pct);
                @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("wav_header_parser verification failed");
        $finish;
    end

    initial begin : stimulus
        int           stream_no;
        int           pick;
        int           phase;
        bit           tight;
        stream_kind_t kind;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Single-byte streams at both byte extremes, then short streams ending after the RIFF and WAVE magic.
        stream_bytes = '{8'h00};
        send_stream();
        stream_bytes = '{8'hFF};
        send_stream();
        stream_bytes.delete();
        push_word(MAGIC_RIFF);
        send_stream();
        stream_bytes.delete();
        push_word(MAGIC_RIFF);
        push_word(32'hFFFF_FFFF);
        push_word(MAGIC_WAVE);
        send_stream();

        phase     = 0;
        stream_no = 0;
        while (bytes_sent < ITEM_TARGET || stream_no < MIN_STREAMS) begin
            if (phase == 0 && bytes_sent >= ITEM_TARGET / 3) begin
                phase      = 1;
                s_idle_pct = 51;
                m_idle_pct = 28;
            end else if (phase == 1 && bytes_sent >= 2 * ITEM_TARGET / 3) begin
                phase        = 2;
                s_idle_pct   = 0;
                m_idle_pct   = 0;
                hold_request = 1'b1;
            end
            // Visit every kind once before drawing them at random.
            if (stream_no < int'(STREAM_KINDS)) begin
                kind = stream_kind_t'(stream_no);
            end else begin
                pick = $urandom_range(99);
                if (pick < 35) kind = STREAM_WELL;
                else if (pick < 45) kind = STREAM_DATA_FIRST;
                else if (pick < 55) kind = STREAM_NO_DATA;
                else if (pick < 65) kind = STREAM_CUT_HEADER;
                else if (pick < 75) kind = STREAM_BAD_MAGIC;
                else if (pick < 85) kind = STREAM_SHORT;
                else if (pick < 92) kind = STREAM_HUGE_CHUNK;
                else kind = STREAM_NOISE;
            end
            tight = (stream_no == 0) || ($urandom_range(7) == 0);
            build_stream(kind, tight);
            send_stream();
            stream_no++;
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d byte beats in %0d streams: well-formed, truncated, corrupted,",
                 bytes_sent, headers_checked);
        $display("oversized-chunk and noise; %0d valid headers, %0d data chunks located",
                 headers_valid, chunks_found);
        if (fail_count == 0 && pending_count == 0) begin
            $display("wav_header_parser verification clean");
        end else begin
            $display("wav_header_parser verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/whp_pkg.sv
sv/whp_in_reg.sv
sv/whp_core.sv
sv/wav_header_parser.sv
tb/wav_header_parser_checker.sv
tb/wav_header_parser_tb.sv
